// ----- rtl/core/bpec_pkg.sv -----
// Shared constants and types for the button press event classifier.
// Used by button_press_event_classifier_top; depends on nothing else.
`timescale 1ns / 1ps

package bpec_pkg;

   // Button count and the field widths it settles
   localparam int NUM_BUTTONS = 10;
   localparam int BTN_W       = 4;
   localparam int BTN_IDX_W   = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

   localparam int FUNC_W      = 3;
   localparam int KIND_W      = 2;
   localparam int STATUS_W    = 3;
   localparam int MODES_W     = 20;
   localparam int DELAY_W     = 16;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 20;

   localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd100;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_MODES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STARTUP_DELAY = 2'd1;

   // Input item function codes (5 to 7 carry no meaning)
   localparam logic [FUNC_W-1:0] FUNC_TICK   = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_RISE   = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_FALL   = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_LONG   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_STATUS = 3'd4;

   // Per-button mode; the fourth code behaves like falling-short
   typedef enum logic [1:0] {
      MODE_FALL_SHORT = 2'd0,
      MODE_RISE_SHORT = 2'd1,
      MODE_SHORT_LONG = 2'd2,
      MODE_FALL_ALT   = 2'd3
   } mode_type;

   // Latched event per button
   typedef enum logic [1:0] {
      EV_NONE         = 2'd0,
      EV_SHORT        = 2'd1,
      EV_LONG_PRESS   = 2'd2,
      EV_LONG_RELEASE = 2'd3
   } event_type;

   // Result kind
   typedef enum logic [KIND_W-1:0] {
      KIND_SHORT        = 2'd0,
      KIND_LONG_PRESS   = 2'd1,
      KIND_LONG_RELEASE = 2'd2,
      KIND_STATUS       = 2'd3
   } kind_type;

endpackage

// ----- rtl/core/button_press_event_classifier_top.sv -----
// Button press event classifier: per-button short/long press decode, latch and status read.
// Depends on bpec_pkg.
`timescale 1ns / 1ps

//  channel | ports                                             | direction
//  --------+---------------------------------------------------+----------
//  req     | req_valid, req_stall, req_func, req_button,       | in
//          | req_long_level                                    |
//  rsp     | rsp_valid, rsp_stall, rsp_kind, rsp_button_out,   | out
//          | rsp_status_bits                                   |
//  csr     | csr_we, csr_index, csr_wdata                      | in
//
// One item per cycle while req_stall is low: the item is decoded against the button state in
// the cycle it is accepted (a csr write in that cycle drops it) and its result, if any,
// appears in the result register in the next cycle. req_stall is high only while the result
// register is full and rsp_stall holds it. Synchronous active-high reset clears all latched
// events, disarms the block and loads the startup counter with the reset delay of 100 ticks.

module button_press_event_classifier_top (
   input  logic                            clock,
   input  logic                            reset,
   // input channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [bpec_pkg::FUNC_W-1:0]     req_func,
   input  logic [bpec_pkg::BTN_W-1:0]      req_button,
   input  logic                            req_long_level,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [bpec_pkg::KIND_W-1:0]     rsp_kind,
   output logic [bpec_pkg::BTN_W-1:0]      rsp_button_out,
   output logic [bpec_pkg::STATUS_W-1:0]   rsp_status_bits,
   // configuration
   input  logic                            csr_we,
   input  logic [bpec_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bpec_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import bpec_pkg::*;

   localparam logic [BTN_W:0] NUM_BUTTONS_V = (BTN_W+1)'(NUM_BUTTONS);

   // State
   logic [MODES_W-1:0]  modes_ff, modes_in;
   logic [DELAY_W-1:0]  delay_ff, delay_in;
   logic [DELAY_W-1:0]  count_ff, count_in;
   logic                armed_ff, armed_in;
   event_type           latched_ff [NUM_BUTTONS];
   event_type           latched_in [NUM_BUTTONS];

   // Result register
   logic                rsp_valid_ff, rsp_valid_in;
   kind_type            kind_ff, kind_in;
   logic [BTN_W-1:0]    button_ff, button_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   logic                accept;
   logic                btn_ok;
   logic [BTN_IDX_W-1:0] btn_idx;
   logic [31:0]         modes_ext;
   mode_type            mode;
   event_type           cur_ev;
   event_type           new_ev;
   logic                result;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   // Button lookup: range check, latched event and mode (bits above the register read 0)
   assign btn_ok    = {1'b0, req_button} < NUM_BUTTONS_V;
   assign btn_idx   = req_button[BTN_IDX_W-1:0];
   assign modes_ext = {{(32-MODES_W){1'b0}}, modes_ff};
   assign mode      = mode_type'(modes_ext[{req_button, 1'b0} +: 2]);
   assign cur_ev    = btn_ok ? latched_ff[btn_idx] : EV_NONE;

   // Item decode and state update
   always_comb begin
      modes_in   = modes_ff;
      delay_in   = delay_ff;
      count_in   = count_ff;
      armed_in   = armed_ff;
      latched_in = latched_ff;
      new_ev     = EV_NONE;
      result     = 1'b0;
      kind_in    = KIND_STATUS;
      button_in  = req_button;
      status_in  = '0;

      if (csr_we) begin
         unique case (csr_index)
            CSR_CHANNEL_MODES: begin
               modes_in = csr_wdata[MODES_W-1:0];
               for (int i = 0; i < NUM_BUTTONS; i++) begin
                  latched_in[i] = EV_NONE;
               end
               count_in = delay_ff;
               armed_in = 1'b0;
            end
            CSR_STARTUP_DELAY: begin
               delay_in = csr_wdata[DELAY_W-1:0];
               count_in = csr_wdata[DELAY_W-1:0];
               armed_in = 1'b0;
            end
            default: begin
            end
         endcase
      end else if (accept) begin
         unique case (req_func)
            FUNC_TICK: begin
               if (count_ff != '0) begin
                  count_in = count_ff - 1'b1;
               end else begin
                  armed_in = 1'b1;
               end
            end
            FUNC_RISE: begin
               if (btn_ok && mode == MODE_RISE_SHORT) new_ev = EV_SHORT;
            end
            FUNC_FALL: begin
               if (btn_ok) begin
                  unique case (mode)
                     MODE_SHORT_LONG: new_ev = req_long_level ? EV_LONG_RELEASE : EV_SHORT;
                     MODE_RISE_SHORT: new_ev = EV_NONE;
                     default:         new_ev = EV_SHORT;
                  endcase
               end
            end
            FUNC_LONG: begin
               if (btn_ok && mode == MODE_SHORT_LONG) new_ev = EV_LONG_PRESS;
            end
            FUNC_STATUS: begin
               // one-hot view of the latched event, then clear it
               result = 1'b1;
               unique case (cur_ev)
                  EV_SHORT:        status_in = 3'b001;
                  EV_LONG_PRESS:   status_in = 3'b010;
                  EV_LONG_RELEASE: status_in = 3'b100;
                  default:         status_in = 3'b000;
               endcase
               if (btn_ok) latched_in[btn_idx] = EV_NONE;
            end
            default: begin
            end
         endcase

         // Events count only once armed, and replace the latched one
         if (new_ev != EV_NONE && armed_ff) begin
            result              = 1'b1;
            latched_in[btn_idx] = new_ev;
            unique case (new_ev)
               EV_LONG_PRESS:   kind_in = KIND_LONG_PRESS;
               EV_LONG_RELEASE: kind_in = KIND_LONG_RELEASE;
               default:         kind_in = KIND_SHORT;
            endcase
         end
      end
   end

   // Result register handshake
   always_comb begin
      if (accept) begin
         rsp_valid_in = result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modes_ff     <= '0;
         delay_ff     <= DELAY_RESET;
         count_ff     <= DELAY_RESET;
         armed_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            latched_ff[i] <= EV_NONE;
         end
      end else begin
         modes_ff     <= modes_in;
         delay_ff     <= delay_in;
         count_ff     <= count_in;
         armed_ff     <= armed_in;
         rsp_valid_ff <= rsp_valid_in;
         latched_ff   <= latched_in;
      end
   end

   // Result payload, loaded only with a new result
   always_ff @(posedge clock) begin
      if (accept && result && !csr_we) begin
         kind_ff   <= kind_in;
         button_ff <= button_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_button_out  = button_ff;
   assign rsp_status_bits = status_ff;

endmodule
